[rtl/core/ttt_pkg.sv]
// Shared types and constants for the timed trigger table.
// Item structs, per-cell entry and control structs, mode codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_ADD     = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_ms;
    logic [31:0] due_time;
    logic [31:0] period;
    logic [7:0]  tag;
  } in_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_tag;
    logic       add_rejected;
  } out_t;

  // One table slot as held in a cell
  typedef struct packed {
    logic        occ;
    logic [31:0] due;
    logic [31:0] period;
    logic [7:0]  tag;
  } entry_t;

  typedef struct packed {
    logic add;
    logic fire;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RESOLVE
  } state_t;

endpackage

`default_nettype wire

[rtl/core/timed_trigger_table.sv]
// Top level of the timed trigger table: command FSM, base time and a row
// of ttt_cell slots. Depends on ttt_pkg and ttt_cell.
//
//   channel | ports                        | handshake
//   input   | start, busy, in_item         | accepted when start && !busy
//   result  | out_valid, out_item          | one-cycle strobe, no backpressure
//
// A tick runs in steps from accept to result strobe: elapsed time, per-cell
// compare, then the priority/shift ripple along the cell row updates the table.
// Add, restart and unused modes skip compare and ripple. busy is high from the
// cycle after accept until the result strobe; a new item is taken as it shows.
// Synchronous active-low reset empties the table and zeroes the base time.
`timescale 1ns / 1ps
`default_nettype none

module timed_trigger_table #(
  parameter int TABLE_DEPTH = ttt_pkg::TABLE_DEPTH_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  ttt_pkg::in_t   in_item,
  output logic           out_valid,
  output ttt_pkg::out_t  out_item
);

  ttt_pkg::state_t    state_r, state_nxt;
  ttt_pkg::in_t       item_r;
  logic [31:0]        base_r, base_nxt;
  logic [31:0]        elapsed_r;
  logic               out_valid_r, out_valid_nxt;
  ttt_pkg::out_t      out_item_r, out_item_nxt;
  ttt_pkg::cell_ctl_t ctl;
  logic               accept;

  ttt_pkg::entry_t    ent [TABLE_DEPTH];
  logic               seen  [TABLE_DEPTH+1];
  logic               shift [TABLE_DEPTH+1];
  logic [7:0]         tagc  [TABLE_DEPTH+1];

  assign busy      = (state_r != ttt_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign seen[0]  = 1'b0;
  assign shift[0] = 1'b0;
  assign tagc[0]  = 8'd0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ttt_pkg::entry_t nxt_ent;
    logic            prv_occ;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nxt_ent = '0;
    end else begin : g_mid
      assign nxt_ent = ent[i+1];
    end
    if (i == 0) begin : g_head
      assign prv_occ = 1'b1;
    end else begin : g_body
      assign prv_occ = ent[i-1].occ;
    end
    ttt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .elapsed   (elapsed_r),
      .add_item  (item_r),
      .prev_occ  (prv_occ),
      .seen_in   (seen[i]),
      .shift_in  (shift[i]),
      .tag_in    (tagc[i]),
      .next_ent  (nxt_ent),
      .ent       (ent[i]),
      .seen_out  (seen[i+1]),
      .shift_out (shift[i+1]),
      .tag_out   (tagc[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    ctl           = '0;
    unique case (state_r)
      ttt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ttt_pkg::ST_EVAL;
        end
      end
      ttt_pkg::ST_EVAL: begin
        if (item_r.mode == ttt_pkg::MODE_TICK) begin
          // cells register their compare this cycle
          state_nxt = ttt_pkg::ST_RESOLVE;
        end else begin
          state_nxt     = ttt_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          if (item_r.mode == ttt_pkg::MODE_ADD) begin
            ctl.add                   = 1'b1;
            out_item_nxt.add_rejected = ent[TABLE_DEPTH-1].occ;
          end else if (item_r.mode == ttt_pkg::MODE_RESTART) begin
            base_nxt = item_r.now_ms;
          end
        end
      end
      ttt_pkg::ST_RESOLVE: begin
        ctl.fire               = 1'b1;
        state_nxt              = ttt_pkg::ST_IDLE;
        out_valid_nxt          = 1'b1;
        out_item_nxt.fired     = seen[TABLE_DEPTH];
        out_item_nxt.fired_tag = tagc[TABLE_DEPTH];
      end
      default: begin
        state_nxt = ttt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttt_pkg::ST_IDLE;
      base_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (accept) begin
      item_r    <= in_item;
      elapsed_r <= in_item.now_ms - base_r;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ttt_cell.sv]
// One slot of the trigger table chain: holds an entry, checks it against
// the elapsed time and passes priority, shift and tag along the row.
// Depends on ttt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttt_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ttt_pkg::cell_ctl_t  ctl,
  input  wire  [31:0]         elapsed,
  input  ttt_pkg::in_t        add_item,
  input  wire                 prev_occ,
  input  wire                 seen_in,
  input  wire                 shift_in,
  input  wire  [7:0]          tag_in,
  input  ttt_pkg::entry_t     next_ent,
  output ttt_pkg::entry_t     ent,
  output logic                seen_out,
  output logic                shift_out,
  output logic [7:0]          tag_out
);

  logic            occ_r, occ_nxt;
  logic [31:0]     due_r, due_nxt;
  logic [31:0]     period_r, period_nxt;
  logic [7:0]      tag_r, tag_nxt;
  logic            hit_r;
  logic            first;
  logic            one_shot;

  // first due entry in table order
  assign first     = hit_r & ~seen_in;
  assign one_shot  = (period_r == 32'd0);
  assign seen_out  = seen_in | hit_r;
  assign shift_out = shift_in | (first & one_shot);
  assign tag_out   = tag_in | (first ? tag_r : 8'd0);

  assign ent = '{occ: occ_r, due: due_r, period: period_r, tag: tag_r};

  always_comb begin
    occ_nxt    = occ_r;
    due_nxt    = due_r;
    period_nxt = period_r;
    tag_nxt    = tag_r;
    if (ctl.add && !occ_r && prev_occ) begin
      occ_nxt    = 1'b1;
      due_nxt    = add_item.due_time;
      period_nxt = add_item.period;
      tag_nxt    = add_item.tag;
    end else if (ctl.fire) begin
      if (shift_out) begin
        // close up: take the neighbor's entry
        occ_nxt    = next_ent.occ;
        due_nxt    = next_ent.due;
        period_nxt = next_ent.period;
        tag_nxt    = next_ent.tag;
      end else if (first) begin
        due_nxt = due_r + period_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    due_r    <= due_nxt;
    period_r <= period_nxt;
    tag_r    <= tag_nxt;
    hit_r    <= occ_r && (due_r <= elapsed);
  end

endmodule

`default_nettype wire

[tb/timed_trigger_table_tb.sv]
// Self-checking testbench for timed_trigger_table: directed items, then random phases.
// A scoreboard class tracks the trigger table and predicts every result.
// Depends on ttt_pkg and the timed_trigger_table RTL.
`timescale 1ns / 1ps

class trigger_scoreboard;
  localparam int DEPTH = ttt_pkg::TABLE_DEPTH_DEF;

  logic [31:0] due_q[DEPTH];
  logic [31:0] period_q[DEPTH];
  logic [7:0]  tag_q[DEPTH];
  int          entry_count;
  logic [31:0] base_ms;

  ttt_pkg::out_t pending_results[$];
  int n_items, n_checked, n_fired, n_rejected, n_errors;

  function new();
    entry_count = 0;
    base_ms = '0;
    n_items = 0;
    n_checked = 0;
    n_fired = 0;
    n_rejected = 0;
    n_errors = 0;
  endfunction

  // Apply one accepted item to the tracked table and queue the result it causes
  function void note_item(ttt_pkg::in_t it);
    ttt_pkg::out_t res;
    logic [31:0] elapsed;
    int hit;
    res = '0;
    hit = -1;
    n_items++;
    case (it.mode)
      ttt_pkg::MODE_TICK: begin
        elapsed = it.now_ms - base_ms;
        for (int i = 0; i < entry_count; i++) begin
          if (hit < 0 && due_q[i] <= elapsed) hit = i;
        end
        if (hit >= 0) begin
          res.fired = 1'b1;
          res.fired_tag = tag_q[hit];
          n_fired++;
          if (period_q[hit] != 0) begin
            due_q[hit] = due_q[hit] + period_q[hit];
          end else begin
            // one-shot: later entries close up
            for (int k = hit; k + 1 < entry_count; k++) begin
              due_q[k] = due_q[k + 1];
              period_q[k] = period_q[k + 1];
              tag_q[k] = tag_q[k + 1];
            end
            entry_count--;
          end
        end
      end
      ttt_pkg::MODE_ADD: begin
        if (entry_count >= DEPTH) begin
          res.add_rejected = 1'b1;
          n_rejected++;
        end else begin
          due_q[entry_count] = it.due_time;
          period_q[entry_count] = it.period;
          tag_q[entry_count] = it.tag;
          entry_count++;
        end
      end
      ttt_pkg::MODE_RESTART: begin
        base_ms = it.now_ms;
      end
      default: begin
      end
    endcase
    pending_results.insert(pending_results.size(), res);
  endfunction

  function void compare_field(string name, int expv, int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
      n_errors++;
    end
  endfunction

  function void check_result(ttt_pkg::out_t got);
    ttt_pkg::out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      n_errors++;
    end else begin
      want = pending_results.pop_front();
      n_checked++;
      compare_field("fired", want.fired, got.fired);
      compare_field("fired_tag", want.fired_tag, got.fired_tag);
      compare_field("add_rejected", want.add_rejected, got.add_rejected);
    end
  endfunction

  function int pending();
    return pending_results.size();
  endfunction
endclass

module timed_trigger_table_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 225;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  ttt_pkg::in_t  in_item = '0;
  logic          busy;
  logic          out_valid;
  ttt_pkg::out_t out_item;

  trigger_scoreboard sb = new();
  int cycle_count = 0;
  logic [31:0] clock_ms = '0;
  ttt_pkg::in_t directed_q[$];

  timed_trigger_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample handshakes on the edge; the block updates its outputs with NBAs
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) sb.check_result(out_item);
      if (start && busy === 1'b0) sb.note_item(in_item);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic ttt_pkg::in_t mk_item(logic [1:0] mode, logic [31:0] now,
                                           logic [31:0] due, logic [31:0] per,
                                           logic [7:0] tag);
    ttt_pkg::in_t it;
    it.mode = mode;
    it.now_ms = now;
    it.due_time = due;
    it.period = per;
    it.tag = tag;
    return it;
  endfunction

  function void stage_item(ttt_pkg::in_t it);
    directed_q.insert(directed_q.size(), it);
  endfunction

  // Mostly a moving clock with small relative due times so entries keep firing
  function ttt_pkg::in_t random_item(int add_pct);
    ttt_pkg::in_t it;
    int pick;
    int sel;
    pick = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(0, 20);
    it.now_ms = ($urandom_range(19) == 0) ? $urandom : clock_ms;
    it.tag = 8'($urandom_range(255));
    it.due_time = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 300);
    sel = $urandom_range(99);
    if (sel < 35) it.period = '0;
    else if (sel < 85) it.period = $urandom_range(1, 60);
    else it.period = $urandom;
    if (pick < add_pct) it.mode = ttt_pkg::MODE_ADD;
    else if (pick < add_pct + 8) it.mode = ttt_pkg::MODE_RESTART;
    else if (pick < add_pct + 12) it.mode = MODE_UNUSED;
    else it.mode = ttt_pkg::MODE_TICK;
    return it;
  endfunction

  // Present one item and hold it until taken; start stays high for a follow-on item unless an idle gap drops it
  task automatic send_item(ttt_pkg::in_t it, int idle_pct);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_plan[4];
    int add_plan[4];

    idle_plan = '{0, 63, 0, 20};
    add_plan = '{30, 40, 20, 35};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    stage_item(mk_item(ttt_pkg::MODE_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    stage_item(mk_item(ttt_pkg::MODE_RESTART, 32'hFFFF_FFF0, 32'h0, 32'h0, 8'h0));
    // one-shot and periodic adds
    stage_item(mk_item(ttt_pkg::MODE_ADD, 32'h0, 32'h0, 32'h0, 8'hFF));
    stage_item(mk_item(ttt_pkg::MODE_ADD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00));
    stage_item(mk_item(ttt_pkg::MODE_ADD, 32'h0, 32'd5, 32'd7, 8'hA5));
    // elapsed 0
    stage_item(mk_item(ttt_pkg::MODE_TICK, 32'hFFFF_FFF0, 32'h0, 32'h0, 8'h0));
    // elapsed wraps
    stage_item(mk_item(ttt_pkg::MODE_TICK, 32'h0000_0004, 32'h0, 32'h0, 8'h0));
    // due wraps
    stage_item(mk_item(ttt_pkg::MODE_TICK, 32'hFFFF_FFEF, 32'h0, 32'h0, 8'h0));
    stage_item(mk_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    stage_item(mk_item(ttt_pkg::MODE_RESTART, 32'h0, 32'h0, 32'h0, 8'h0));
    // none due
    stage_item(mk_item(ttt_pkg::MODE_TICK, 32'h0, 32'h0, 32'h0, 8'h0));
    for (int i = 0; i < ttt_pkg::TABLE_DEPTH_DEF - 2; i++)
      stage_item(mk_item(ttt_pkg::MODE_ADD, 32'h0, 32'd100 + 32'(i),
                         (i % 2) ? 32'd3 : 32'd0, 8'(8'h10 + i)));
    // full table
    stage_item(mk_item(ttt_pkg::MODE_ADD, 32'h0, 32'h0, 32'h0, 8'h5A));

    foreach (directed_q[i]) send_item(directed_q[i], 0);
    start <= 1'b0;
    @(posedge clk);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(add_plan[p]), idle_plan[p]);
      start <= 1'b0;
      @(posedge clk);
      // hold off until the table has answered everything sent so far
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d items, %0d results checked, in %0d cycles",
             sb.n_items, sb.n_checked, cycle_count);
    $display("%0d ticks fired an entry, %0d adds hit a full table",
             sb.n_fired, sb.n_rejected);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.n_errors, sb.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ttt_pkg.sv
rtl/core/ttt_cell.sv
rtl/core/timed_trigger_table.sv
tb/timed_trigger_table_tb.sv
